### src/dpd_pkg.sv
// ----------------------------------------------------------------------------
// DPD pair force package
// Item types, register indexes, sideband types and pipeline constants shared
// by the pair force pipeline.
// ----------------------------------------------------------------------------
package dpd_pkg;

  // Fraction bits of the Q12.20 format and of the Q4.12 gaussian sample.
  localparam int QF       = 20;
  localparam int WF       = 12;
  // One root bit per square root stage, one quotient bit per divider stage.
  localparam int SQ_BITS  = 32;
  localparam int DIV_BITS = 21;
  // Divider lanes: three unit vector components and the weight.
  localparam int NUM_DIV  = 4;
  localparam int LANE_WR  = 3;

  localparam logic [31:0] Q_ONE = 32'h0010_0000;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_FRICTION = 2'd0,
    REG_NOISE    = 2'd1,
    REG_STEP     = 2'd2,
    REG_CUTOFF   = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic signed [31:0] sep_x;
    logic signed [31:0] sep_y;
    logic signed [31:0] sep_z;
    logic signed [31:0] relvel_x;
    logic signed [31:0] relvel_y;
    logic signed [31:0] relvel_z;
    logic signed [15:0] gauss_sample;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
    logic               zero_distance;
  } out_item_t;

  // Sideband that travels alongside the square root stages.
  typedef struct packed {
    logic             zero;
    logic [2:0]       sep_neg;
    logic [2:0][31:0] sep_mag;
    logic [2:0][31:0] vel;
    logic [15:0]      gauss;
  } sq_side_t;

  // Sideband that travels alongside the divider stages.
  typedef struct packed {
    logic             zero;
    logic             wr_zero;
    logic [2:0]       sep_neg;
    logic [2:0][31:0] vel;
    logic [15:0]      gauss;
  } dv_side_t;

endpackage

### src/dpd_sqrt.sv
// ----------------------------------------------------------------------------
// DPD pipelined square root
// Integer square root of the 64-bit sum of squares, one root bit per stage,
// with the item's sideband carried along.
// ----------------------------------------------------------------------------
module dpd_sqrt import dpd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [2*SQ_BITS-1:0] in_rad,
  input  sq_side_t             in_side,
  output logic                 out_valid,
  output logic [SQ_BITS-1:0]   out_root,
  output sq_side_t             out_side
);

  logic                 v_r    [SQ_BITS];
  logic [2*SQ_BITS-1:0] rem_r  [SQ_BITS];
  logic [SQ_BITS-1:0]   root_r [SQ_BITS];
  sq_side_t             side_r [SQ_BITS];

  for (genvar k = 0; k < SQ_BITS; k++) begin : g_step
    localparam int Bit = SQ_BITS - 1 - k;

    logic                 v_i;
    logic [2*SQ_BITS-1:0] rem_i;
    logic [SQ_BITS-1:0]   root_i;
    sq_side_t             side_i;
    logic [2*SQ_BITS+1:0] term;
    logic [2*SQ_BITS+1:0] diff;
    logic                 take;

    if (k == 0) begin : g_head
      assign v_i    = in_valid;
      assign rem_i  = in_rad;
      assign root_i = '0;
      assign side_i = in_side;
    end else begin : g_tail
      assign v_i    = v_r[k-1];
      assign rem_i  = rem_r[k-1];
      assign root_i = root_r[k-1];
      assign side_i = side_r[k-1];
    end

    // Try to set this root bit: (q + 2^b)^2 - q^2 = q*2^(b+1) + 2^(2b).
    assign term = ({(SQ_BITS + 2)'(0), root_i} << (Bit + 1))
                | ((2*SQ_BITS+2)'(1) << (2*Bit));
    assign diff = {2'b00, rem_i} - term;
    assign take = ({2'b00, rem_i} >= term);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= take ? diff[2*SQ_BITS-1:0] : rem_i;
        root_r[k] <= take ? (root_i | (SQ_BITS'(1) << Bit)) : root_i;
        side_r[k] <= side_i;
      end
    end
  end

  assign out_valid = v_r[SQ_BITS-1];
  assign out_root  = root_r[SQ_BITS-1];
  assign out_side  = side_r[SQ_BITS-1];

endmodule

### src/dpd_div.sv
// ----------------------------------------------------------------------------
// DPD pipelined fractional divider
// Four lanes of floor(num * 2^20 / den) for num <= den, one quotient bit per
// stage by restoring division.
// ----------------------------------------------------------------------------
module dpd_div import dpd_pkg::*; (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  logic                               in_valid,
  input  logic [NUM_DIV-1:0][32:0]           in_num,
  input  logic [NUM_DIV-1:0][31:0]           in_den,
  input  dv_side_t                           in_side,
  output logic                               out_valid,
  output logic [NUM_DIV-1:0][DIV_BITS-1:0]   out_quo,
  output dv_side_t                           out_side
);

  logic                             v_r    [DIV_BITS];
  logic [NUM_DIV-1:0][31:0]         rem_r  [DIV_BITS];
  logic [NUM_DIV-1:0][31:0]         den_r  [DIV_BITS];
  logic [NUM_DIV-1:0][DIV_BITS-1:0] quo_r  [DIV_BITS];
  dv_side_t                         side_r [DIV_BITS];

  for (genvar k = 0; k < DIV_BITS; k++) begin : g_step
    localparam int Bit = DIV_BITS - 1 - k;

    logic                             v_i;
    logic [NUM_DIV-1:0][32:0]         rin_i;
    logic [NUM_DIV-1:0][31:0]         den_i;
    logic [NUM_DIV-1:0][DIV_BITS-1:0] quo_i;
    dv_side_t                         side_i;
    logic [NUM_DIV-1:0][31:0]         rem_nxt;
    logic [NUM_DIV-1:0][DIV_BITS-1:0] quo_nxt;

    if (k == 0) begin : g_head
      assign v_i    = in_valid;
      assign rin_i  = in_num;
      assign den_i  = in_den;
      assign quo_i  = '0;
      assign side_i = in_side;
    end else begin : g_tail
      assign v_i    = v_r[k-1];
      assign den_i  = den_r[k-1];
      assign quo_i  = quo_r[k-1];
      assign side_i = side_r[k-1];
      always_comb begin
        for (int l = 0; l < NUM_DIV; l++) begin
          rin_i[l] = {rem_r[k-1][l], 1'b0};
        end
      end
    end

    // Compare and subtract per lane.
    always_comb begin
      logic [32:0] dif;
      logic        ge;
      for (int l = 0; l < NUM_DIV; l++) begin
        dif        = rin_i[l] - {1'b0, den_i[l]};
        ge         = (rin_i[l] >= {1'b0, den_i[l]});
        rem_nxt[l] = ge ? dif[31:0] : rin_i[l][31:0];
        quo_nxt[l] = quo_i[l] | (DIV_BITS'(ge) << Bit);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_nxt;
        den_r[k]  <= den_i;
        quo_r[k]  <= quo_nxt;
        side_r[k] <= side_i;
      end
    end
  end

  assign out_valid = v_r[DIV_BITS-1];
  assign out_quo   = quo_r[DIV_BITS-1];
  assign out_side  = side_r[DIV_BITS-1];

endmodule

### src/dpd_force.sv
// ----------------------------------------------------------------------------
// DPD force arithmetic
// Weights, projected velocity, random and dissipative terms and the final
// saturated force components, in nine register stages.
// ----------------------------------------------------------------------------
module dpd_force import dpd_pkg::*; (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic                             in_valid,
  input  logic [NUM_DIV-1:0][DIV_BITS-1:0] in_quo,
  input  dv_side_t                         in_side,
  input  logic [31:0]                      friction,
  input  logic [31:0]                      noise_amplitude,
  input  logic [31:0]                      inv_sqrt_step,
  output logic                             out_valid,
  output out_item_t                        out_item
);

  localparam int Stages = 9;

  // Saturate a magnitude with sign to a signed 32-bit value.
  function automatic logic [31:0] sat32(logic [49:0] m, logic neg);
    logic [49:0] nm;
    nm = -m;
    if (m == '0) begin
      return '0;
    end else if (neg) begin
      return (m >= 50'h0_8000_0000) ? 32'h8000_0000 : nm[31:0];
    end else begin
      return (m >= 50'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
    end
  endfunction

  logic [Stages-1:0] v_r;

  // Unit vector magnitude, sign and zero flag carried along.
  logic [DIV_BITS-1:0] emag_r [7][3];
  logic                eneg_r [7][3];
  logic                z_r    [8];

  logic signed [21:0]  e1_r   [3];
  logic signed [31:0]  vel1_r [3];
  logic [DIV_BITS-1:0] wr1_r;
  logic signed [15:0]  g1_r, g2_r, g3_r;

  logic [20:0]         wd2_r;
  logic [31:0]         r1_2_r;
  logic signed [53:0]  p2_r   [3];

  logic signed [54:0]  ip3_r;
  logic [43:0]         r2_3_r;
  logic [31:0]         fw3_r;

  logic [32:0]         imag4_r;
  logic                ipneg4_r;
  logic [47:0]         r3_4_r;
  logic                gneg4_r;
  logic [31:0]         fw4_r;

  logic [44:0]         dmag5_r;
  logic signed [48:0]  rs5_r;
  logic                ipneg5_r;

  logic signed [49:0]  s6_r;

  logic [48:0]         smag7_r;
  logic                sneg7_r;

  logic [49:0]         m8_r   [3];
  logic                neg8_r [3];

  out_item_t           out_r;

  // Combinational products and magnitudes.
  logic [41:0]         prod_wd;
  logic [52:0]         prod_r1;
  logic signed [53:0]  prod_ev [3];
  logic [63:0]         prod_r2;
  logic [52:0]         prod_fw;
  logic signed [54:0]  ip_sum;
  logic [54:0]         ip_abs;
  logic [15:0]         g_mag;
  logic [59:0]         prod_r3;
  logic [64:0]         prod_d;
  logic signed [49:0]  s_nxt;
  logic [49:0]         s_abs;
  logic [69:0]         prod_m  [3];

  assign prod_wd = wr1_r * wr1_r;
  assign prod_r1 = noise_amplitude * wr1_r;
  assign prod_r2 = r1_2_r * inv_sqrt_step;
  assign prod_fw = friction * wd2_r;
  assign ip_sum  = p2_r[0] + p2_r[1] + p2_r[2];
  assign ip_abs  = ip3_r[54] ? 55'(-ip3_r) : 55'(ip3_r);
  assign g_mag   = g3_r[15] ? 16'(-g3_r) : 16'(g3_r);
  assign prod_r3 = r2_3_r * g_mag;
  assign prod_d  = fw4_r * imag4_r;
  assign s_nxt   = ipneg5_r ? (50'(rs5_r) + $signed({5'b0, dmag5_r}))
                            : (50'(rs5_r) - $signed({5'b0, dmag5_r}));
  assign s_abs   = s6_r[49] ? 50'(-s6_r) : 50'(s6_r);

  for (genvar k = 0; k < 3; k++) begin : g_lane
    assign prod_ev[k] = e1_r[k] * vel1_r[k];
    assign prod_m[k]  = emag_r[6][k] * smag7_r;
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[Stages-2:0], in_valid};
    end
  end

  // Data stages.
  always_ff @(posedge clk) begin
    if (en) begin
      // Stage 1: signed unit vector and weight.
      for (int k = 0; k < 3; k++) begin
        emag_r[0][k] <= in_quo[k];
        eneg_r[0][k] <= in_side.sep_neg[k];
        e1_r[k]      <= in_side.sep_neg[k] ? -$signed({1'b0, in_quo[k]})
                                           : $signed({1'b0, in_quo[k]});
        vel1_r[k]    <= $signed(in_side.vel[k]);
      end
      wr1_r  <= in_side.wr_zero ? '0 : in_quo[LANE_WR];
      g1_r   <= $signed(in_side.gauss);
      z_r[0] <= in_side.zero;

      // Carry the unit vector and zero flag.
      for (int i = 1; i < 7; i++) begin
        emag_r[i] <= emag_r[i-1];
        eneg_r[i] <= eneg_r[i-1];
      end
      for (int i = 1; i < 8; i++) begin
        z_r[i] <= z_r[i-1];
      end

      // Stage 2: dissipative weight, first random product, e*v.
      wd2_r  <= prod_wd[40:20];
      r1_2_r <= prod_r1[51:20];
      for (int k = 0; k < 3; k++) begin
        p2_r[k] <= prod_ev[k];
      end
      g2_r <= g1_r;

      // Stage 3: projected velocity sum, time step scale, friction scale.
      ip3_r  <= ip_sum;
      r2_3_r <= prod_r2[63:20];
      fw3_r  <= prod_fw[51:20];
      g3_r   <= g2_r;

      // Stage 4: projection magnitude, random term times the sample.
      imag4_r  <= ip_abs[52:20];
      ipneg4_r <= ip3_r[54];
      r3_4_r   <= prod_r3[59:WF];
      gneg4_r  <= g3_r[15];
      fw4_r    <= fw3_r;

      // Stage 5: dissipative magnitude, signed random term.
      dmag5_r  <= prod_d[64:20];
      rs5_r    <= gneg4_r ? -$signed({1'b0, r3_4_r}) : $signed({1'b0, r3_4_r});
      ipneg5_r <= ipneg4_r;

      // Stage 6: scalar force along the unit vector.
      s6_r <= s_nxt;

      // Stage 7: scalar magnitude and sign.
      smag7_r <= s_abs[48:0];
      sneg7_r <= s6_r[49];

      // Stage 8: component magnitudes.
      for (int k = 0; k < 3; k++) begin
        m8_r[k]   <= prod_m[k][69:20];
        neg8_r[k] <= sneg7_r ^ eneg_r[6][k];
      end

      // Stage 9: saturation and the zero separation case.
      if (z_r[7]) begin
        out_r.force_x       <= '0;
        out_r.force_y       <= '0;
        out_r.force_z       <= '0;
        out_r.zero_distance <= 1'b1;
      end else begin
        out_r.force_x       <= $signed(sat32(m8_r[0], neg8_r[0]));
        out_r.force_y       <= $signed(sat32(m8_r[1], neg8_r[1]));
        out_r.force_z       <= $signed(sat32(m8_r[2], neg8_r[2]));
        out_r.zero_distance <= 1'b0;
      end
    end
  end

  assign out_valid = v_r[Stages-1];
  assign out_item  = out_r;

endmodule

### src/dpd_pair_force.sv
// ----------------------------------------------------------------------------
// DPD random and dissipative pair force
// Streaming pipeline: one particle pair in, one force item out.
// ----------------------------------------------------------------------------
// The block takes one pair item per clock while the output buffer has room
// and returns its force item through three input stages (magnitudes, squares,
// sum), 32 square root stages that produce the distance one bit per stage,
// one setup stage, 21 divider stages that form the unit vector and the cutoff
// weight one bit per stage, nine force arithmetic stages and the output
// register. Throughput is one item per clock unless the skid entry is full;
// a two-entry output buffer keeps the input open while one finished item
// waits. Registers may be written only while no item is in flight.
module dpd_pair_force import dpd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_item,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  logic [31:0] friction_r, noise_r, step_r, cutoff_r;

  logic        en;

  logic        a_v_r;
  sq_side_t    a_side_r;
  logic        b_v_r;
  logic [63:0] b_sq_r [3];
  sq_side_t    b_side_r;
  logic        c_v_r;
  logic [63:0] c_sum_r;
  sq_side_t    c_side_r;

  logic        sq_valid;
  logic [31:0] sq_root;
  sq_side_t    sq_side;

  logic                     p_v_r;
  logic [NUM_DIV-1:0][32:0] p_num_r;
  logic [NUM_DIV-1:0][31:0] p_den_r;
  dv_side_t                 p_side_r;

  logic                             dv_valid;
  logic [NUM_DIV-1:0][DIV_BITS-1:0] dv_quo;
  dv_side_t                         dv_side;

  logic      f_valid;
  out_item_t f_item;

  out_item_t out_r, skid_r;
  logic      out_v_r, skid_v_r;

  logic [2:0][31:0] sep_in, vel_in;
  assign sep_in = {in_item.sep_z, in_item.sep_y, in_item.sep_x};
  assign vel_in = {in_item.relvel_z, in_item.relvel_y, in_item.relvel_x};

  // The pipeline moves whenever the output buffer has room.
  assign en       = !skid_v_r;
  assign in_ready = en;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      friction_r <= Q_ONE;
      noise_r    <= Q_ONE;
      step_r     <= Q_ONE;
      cutoff_r   <= Q_ONE;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_FRICTION: friction_r <= cfg_wdata;
        REG_NOISE:    noise_r    <= cfg_wdata;
        REG_STEP:     step_r     <= cfg_wdata;
        REG_CUTOFF:   cutoff_r   <= cfg_wdata;
      endcase
    end
  end

  // Input stage valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
      p_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= in_valid;
      b_v_r <= a_v_r;
      c_v_r <= b_v_r;
      p_v_r <= sq_valid;
    end
  end

  // Magnitudes, squares and their sum.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        a_side_r.sep_neg[k] <= sep_in[k][31];
        a_side_r.sep_mag[k] <= sep_in[k][31] ? 32'(-sep_in[k]) : sep_in[k];
        b_sq_r[k]           <= a_side_r.sep_mag[k] * a_side_r.sep_mag[k];
      end
      a_side_r.vel   <= vel_in;
      a_side_r.gauss <= in_item.gauss_sample;
      a_side_r.zero  <= (sep_in == '0);
      b_side_r       <= a_side_r;
      c_sum_r        <= b_sq_r[0] + b_sq_r[1] + b_sq_r[2];
      c_side_r       <= b_side_r;
    end
  end

  dpd_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (c_v_r),
    .in_rad    (c_sum_r),
    .in_side   (c_side_r),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  // Divider setup: unit vector lanes and the cutoff weight lane.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        p_num_r[k] <= {1'b0, sq_side.sep_mag[k]};
        p_den_r[k] <= sq_root;
      end
      p_num_r[LANE_WR]  <= {1'b0, cutoff_r} - {1'b0, sq_root};
      p_den_r[LANE_WR]  <= cutoff_r;
      p_side_r.wr_zero  <= (cutoff_r == '0) || (sq_root >= cutoff_r);
      p_side_r.zero     <= sq_side.zero;
      p_side_r.sep_neg  <= sq_side.sep_neg;
      p_side_r.vel      <= sq_side.vel;
      p_side_r.gauss    <= sq_side.gauss;
    end
  end

  dpd_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (p_v_r),
    .in_num    (p_num_r),
    .in_den    (p_den_r),
    .in_side   (p_side_r),
    .out_valid (dv_valid),
    .out_quo   (dv_quo),
    .out_side  (dv_side)
  );

  dpd_force u_force (
    .clk             (clk),
    .rst_n           (rst_n),
    .en              (en),
    .in_valid        (dv_valid),
    .in_quo          (dv_quo),
    .in_side         (dv_side),
    .friction        (friction_r),
    .noise_amplitude (noise_r),
    .inv_sqrt_step   (step_r),
    .out_valid       (f_valid),
    .out_item        (f_item)
  );

  // Output register with one skid entry.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (out_v_r && !out_ready) begin
      if (en && f_valid) begin
        skid_v_r <= 1'b1;
      end
    end else if (skid_v_r) begin
      out_v_r  <= 1'b1;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r <= f_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_v_r && !out_ready) begin
      if (en) begin
        skid_r <= f_item;
      end
    end else if (skid_v_r) begin
      out_r <= skid_r;
    end else begin
      out_r <= f_item;
    end
  end

  assign out_valid = out_v_r;
  assign out_item  = out_r;

endmodule

### sim/tb.sv
// ----------------------------------------------------------------------------
// DPD pair force testbench
// Streams particle pair items through the pair force pipeline under several
// register settings and random valid/ready gaps. It predicts each force item
// in 64-bit integer arithmetic and compares the results field by field, in
// order.
// ----------------------------------------------------------------------------
module tb;
  import dpd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY   = 67;
  localparam int MAX_CYCLE = 2000000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_item;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_wdata = '0;

  // Register copies used for prediction.
  logic [31:0] gamma_q = Q_ONE;
  logic [31:0] sigma_q = Q_ONE;
  logic [31:0] step_q  = Q_ONE;
  logic [31:0] rcut_q  = Q_ONE;

  in_item_t  pending_pairs[$];
  out_item_t expected_forces[$];
  int        send_idle = 0;
  int        recv_idle = 0;
  int        errors = 0;
  int        cycles = 0;
  bit        in_took = 1'b0;

  dpd_pair_force dut (.*);

  always #4 clk = ~clk;

  function automatic longint unsigned mag64(longint x);
    return x < 0 ? -x : x;
  endfunction

  // floor(a * b / 2^20) without overflow for the ranges used here.
  function automatic longint unsigned q20_mul(longint unsigned a, longint unsigned b);
    return a * (b >> 20) + ((a * (b & 64'hF_FFFF)) >> 20);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Expected force on the first particle of a pair.
  function automatic out_item_t pair_force(in_item_t it);
    longint          sp[3], vl[3], ev[3];
    longint unsigned sumsq, dlen, wr, wd, rm, dm, im, m, u;
    longint          w, ip, rs, ds, s;
    out_item_t       r;
    sp[0] = it.sep_x;    sp[1] = it.sep_y;    sp[2] = it.sep_z;
    vl[0] = it.relvel_x; vl[1] = it.relvel_y; vl[2] = it.relvel_z;
    w = it.gauss_sample;
    r = '0;
    sumsq = 0;
    for (int k = 0; k < 3; k++) sumsq += mag64(sp[k]) * mag64(sp[k]);
    if (sumsq == 0) begin
      r.zero_distance = 1'b1;
      return r;
    end
    dlen = int_sqrt(sumsq);
    for (int k = 0; k < 3; k++) begin
      u = (mag64(sp[k]) << 20) / dlen;
      ev[k] = sp[k] < 0 ? -longint'(u) : longint'(u);
    end
    // Cutoff weight; a zero cutoff counts as out of range.
    if (rcut_q == 0 || dlen >= rcut_q) wr = 0;
    else wr = ((longint'(rcut_q) - dlen) << 20) / rcut_q;
    wd = (wr * wr) >> 20;
    ip = 0;
    for (int k = 0; k < 3; k++) ip += ev[k] * vl[k];
    im = mag64(ip) >> 20;
    rm = q20_mul(sigma_q, wr);
    rm = q20_mul(rm, step_q);
    rm = (rm * mag64(w)) >> 12;
    rs = w < 0 ? -longint'(rm) : longint'(rm);
    dm = q20_mul(q20_mul(gamma_q, wd), im);
    ds = ip < 0 ? -longint'(dm) : longint'(dm);
    s = rs - ds;
    for (int k = 0; k < 3; k++) begin
      logic [31:0] f;
      m = q20_mul(mag64(ev[k]), mag64(s));
      if (m == 0) f = 32'd0;
      else if ((s < 0) != (ev[k] < 0)) f = m >= 64'h8000_0000 ? 32'h8000_0000 : -m[31:0];
      else f = m >= 64'h7FFF_FFFF ? 32'h7FFF_FFFF : m[31:0];
      if (k == 0) r.force_x = f;
      else if (k == 1) r.force_y = f;
      else r.force_z = f;
    end
    return r;
  endfunction

  // Random pair: mostly inside a few cutoff radii, some with full-range fields.
  function automatic in_item_t random_pair();
    in_item_t it;
    int       sh;
    it = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 16'($urandom)};
    if ($urandom_range(99) < 70) begin
      sh = $urandom_range(31, 8);
      it.sep_x = $signed(it.sep_x) >>> sh;
      it.sep_y = $signed(it.sep_y) >>> sh;
      it.sep_z = $signed(it.sep_z) >>> sh;
      if ($urandom_range(1)) begin
        it.relvel_x = $signed(it.relvel_x) >>> 8;
        it.relvel_y = $signed(it.relvel_y) >>> 8;
        it.relvel_z = $signed(it.relvel_z) >>> 8;
      end
    end
    if ($urandom_range(19) == 0) begin
      it.sep_x = '0; it.sep_y = '0; it.sep_z = '0;
    end
    return it;
  endfunction

  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_FRICTION: gamma_q = val;
      REG_NOISE:    sigma_q = val;
      REG_STEP:     step_q  = val;
      REG_CUTOFF:   rcut_q  = val;
    endcase
  endtask

  task automatic drain();
    while (pending_pairs.size() != 0 || in_valid || expected_forces.size() != 0)
      @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  // Input driver: a new item goes out only after the previous one was taken.
  always @(negedge clk) begin
    if (!in_valid || in_took) begin
      if (pending_pairs.size() != 0 && $urandom_range(99) >= send_idle) begin
        in_item <= pending_pairs.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= rst_n && ($urandom_range(99) >= recv_idle);
  end

  // Monitor: predict on input accept, check on output accept.
  always @(posedge clk) begin
    in_took = in_valid && in_ready && rst_n;
    if (in_took) expected_forces.push_back(pair_force(in_item));
    if (rst_n && out_valid && out_ready) begin
      if (expected_forces.size() == 0) begin
        $error("unexpected force item %h", out_item);
        errors++;
      end else begin
        out_item_t e;
        e = expected_forces.pop_front();
        if (out_item.force_x !== e.force_x) begin
          $error("force_x expected %h actual %h", e.force_x, out_item.force_x);
          errors++;
        end
        if (out_item.force_y !== e.force_y) begin
          $error("force_y expected %h actual %h", e.force_y, out_item.force_y);
          errors++;
        end
        if (out_item.force_z !== e.force_z) begin
          $error("force_z expected %h actual %h", e.force_z, out_item.force_z);
          errors++;
        end
        if (out_item.zero_distance !== e.zero_distance) begin
          $error("zero_distance expected %b actual %b", e.zero_distance,
                 out_item.zero_distance);
          errors++;
        end
      end
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycles++;
    if (cycles > MAX_CYCLE) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    logic [31:0] gset[6], nset[6], sset[6], cset[6];
    in_item_t    it;
    gset = '{Q_ONE, 32'hFFFF_FFFF, 32'd0, 32'h0040_0000, $urandom, 32'h0008_0000};
    nset = '{Q_ONE, 32'hFFFF_FFFF, 32'd0, 32'h0300_0000, $urandom, 32'h0020_0000};
    sset = '{Q_ONE, 32'hFFFF_FFFF, 32'd0, 32'h0002_0000, $urandom, 32'h0100_0000};
    cset = '{Q_ONE, 32'hFFFF_FFFF, 32'd0, 32'h0020_0000, 32'd1,    32'h0080_0000};
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed pairs at reset settings: zero separation, extremes, cutoff edge.
    send_idle = 18;
    recv_idle = 67;
    pending_pairs.push_back('0);
    it = '0; it.relvel_x = 32'h7FFF_FFFF; it.gauss_sample = 16'h7FFF;
    pending_pairs.push_back(it);
    it = '0; it.sep_x = 32'h0008_0000; it.relvel_x = 32'h8000_0000;
    it.gauss_sample = 16'h8000;
    pending_pairs.push_back(it);
    it.sep_x = Q_ONE;
    pending_pairs.push_back(it);
    it.sep_x = Q_ONE - 1;
    it.gauss_sample = 16'h7FFF;
    pending_pairs.push_back(it);
    it = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
           32'h8000_0000, 32'h8000_0000, 16'h8000};
    pending_pairs.push_back(it);
    it = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
           32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h7FFF};
    pending_pairs.push_back(it);
    it = '{-32'sd1000, 32'sd2000, -32'sd3000, 32'h8000_0000, 32'h7FFF_FFFF,
           -32'sd1, 16'hFFFF};
    pending_pairs.push_back(it);
    it = '{32'sd1, 32'sd0, 32'sd0, 32'h7FFF_FFFF, 32'sd0, 32'sd0, 16'h0001};
    pending_pairs.push_back(it);
    it = '{32'sd0, 32'sd0, -32'sd1, 32'sd0, 32'sd0, 32'h8000_0000, 16'h8000};
    pending_pairs.push_back(it);
    drain();

    // Register settings, each followed by a random stream.
    for (int ph = 0; ph < 6; ph++) begin
      if (ph < 2) begin
        send_idle = 18; recv_idle = 67;
      end else if (ph < 4) begin
        send_idle = 67; recv_idle = 18;
      end else begin
        send_idle = 0; recv_idle = 0;
      end
      write_reg(REG_FRICTION, gset[ph]);
      write_reg(REG_NOISE, nset[ph]);
      write_reg(REG_STEP, sset[ph]);
      write_reg(REG_CUTOFF, cset[ph]);
      for (int i = 0; i < 305; i++) begin
        pending_pairs.push_back(random_pair());
        // Halfway through, hold the sender until every force item is back.
        if (i == 150) begin
          while (pending_pairs.size() != 0 || in_valid || expected_forces.size() != 0)
            @(posedge clk);
        end
      end
      drain();
    end

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
